// ===== design/lrb_pkg.sv =====
`default_nettype none
package lrb_pkg;

  localparam int BMP_COLS = 192;
  localparam int BMP_ROWS = 160;

  localparam int COORD_W = 10;
  localparam int BOUND_W = COORD_W + 1;
  localparam int X_W     = $clog2(BMP_COLS);
  localparam int Y_W     = $clog2(BMP_ROWS);
  localparam int ERR_W   = COORD_W + 2;
  localparam int E2_W    = ERR_W + 1;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] probe_x;
    logic [COORD_W-1:0] probe_y;
  } req_t;

  typedef struct packed {
    logic status;
    logic pixel_black;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic clr_step;
    logic res_load;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       line_ok;
    logic       line_end;
    logic       clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/lrb_datapath.sv =====
`default_nettype none
module lrb_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lrb_pkg::req_t     req,
  input  lrb_pkg::dp_ctl_t  ctl,
  output lrb_pkg::dp_stat_t stat,
  output lrb_pkg::rsp_t     rsp
);
  import lrb_pkg::*;

  function automatic logic inside_raster(input logic [COORD_W-1:0] cx,
                                         input logic [COORD_W-1:0] cy);
    inside_raster = ({1'b0, cx} < BOUND_W'(BMP_COLS)) &&
                    ({1'b0, cy} < BOUND_W'(BMP_ROWS));
  endfunction

  logic [1:0]         op;
  logic [COORD_W-1:0] x, y, xe, ye, px, py;
  logic               sx, sy;
  logic [COORD_W-1:0] dx, ady;
  logic signed [ERR_W-1:0] err;
  logic               line_ok, probe_ok;
  logic [Y_W-1:0]     clr_row;
  rsp_t               result;

  logic [BMP_COLS-1:0] mem [BMP_ROWS];
  logic [BMP_COLS-1:0] row_q;

  logic [COORD_W-1:0]      ld_dx, ld_dy;
  logic signed [ERR_W-1:0] ld_err;
  logic signed [ERR_W-1:0] dx_s, dy_s, err_next;
  logic signed [E2_W-1:0]  e2;
  logic                    go_x, go_y;
  logic                    line_end, clr_last;

  always_comb begin
    ld_dx  = (req.end_x > req.start_x) ? req.end_x - req.start_x : req.start_x - req.end_x;
    ld_dy  = (req.end_y > req.start_y) ? req.end_y - req.start_y : req.start_y - req.end_y;
    ld_err = $signed({{(ERR_W-COORD_W){1'b0}}, ld_dx}) -
             $signed({{(ERR_W-COORD_W){1'b0}}, ld_dy});
  end

  // doubled error term walk, one pixel per step
  always_comb begin
    dx_s     = $signed({{(ERR_W-COORD_W){1'b0}}, dx});
    dy_s     = -$signed({{(ERR_W-COORD_W){1'b0}}, ady});
    e2       = $signed({err, 1'b0});
    go_x     = e2 >= $signed({dy_s[ERR_W-1], dy_s});
    go_y     = e2 <= $signed({dx_s[ERR_W-1], dx_s});
    err_next = err + (go_x ? dy_s : '0) + (go_y ? dx_s : '0);
    line_end = (x == xe) && (y == ye);
    clr_last = clr_row == Y_W'(BMP_ROWS - 1);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op       <= req.operation;
      x        <= req.start_x;
      y        <= req.start_y;
      xe       <= req.end_x;
      ye       <= req.end_y;
      px       <= req.probe_x;
      py       <= req.probe_y;
      sx       <= !(req.start_x < req.end_x);
      sy       <= !(req.start_y < req.end_y);
      dx       <= ld_dx;
      ady      <= ld_dy;
      err      <= ld_err;
      line_ok  <= inside_raster(req.start_x, req.start_y) &&
                  inside_raster(req.end_x, req.end_y);
      probe_ok <= inside_raster(req.probe_x, req.probe_y);
    end else if (ctl.step) begin
      err <= err_next;
      if (go_x) begin
        x <= sx ? x - 1'b1 : x + 1'b1;
      end
      if (go_y) begin
        y <= sy ? y - 1'b1 : y + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (ctl.clr_step) begin
      clr_row <= clr_last ? '0 : clr_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      mem[clr_row] <= '0;
    end else if (ctl.step) begin
      mem[y[Y_W-1:0]][x[X_W-1:0]] <= 1'b1;
    end
    row_q <= mem[py[Y_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      result.status      <= ((op == OP_DRAW) && !line_ok) || ((op == OP_READ) && !probe_ok);
      result.pixel_black <= (op == OP_READ) && probe_ok && row_q[px[X_W-1:0]];
    end
  end

  assign stat.op       = op;
  assign stat.line_ok  = line_ok;
  assign stat.line_end = line_end;
  assign stat.clr_last = clr_last;
  assign rsp           = result;

endmodule
`default_nettype wire

// ===== design/lrb_ctrl.sv =====
`default_nettype none
module lrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  lrb_pkg::dp_stat_t stat,
  output lrb_pkg::dp_ctl_t  ctl
);
  import lrb_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DECODE, S_CLEAR, S_DRAW, S_RESULT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = state != S_IDLE;

  always_comb begin
    ctl.load     = (state == S_IDLE) && req_valid;
    ctl.step     = state == S_DRAW;
    ctl.clr_step = (state == S_INIT) || (state == S_CLEAR);
    ctl.res_load = (state == S_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (stat.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (stat.op)
            OP_CLEAR: state <= S_CLEAR;
            OP_DRAW:  state <= stat.line_ok ? S_DRAW : S_RESULT;
            default:  state <= S_RESULT;
          endcase
        end
        S_CLEAR: begin
          if (stat.clr_last) begin
            state <= S_RESULT;
          end
        end
        S_DRAW: begin
          if (stat.line_end) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  a_res_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |=> rsp_valid)
    else $error("result load did not raise rsp_valid");

  a_draw_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW && stat.line_end) |=> state == S_RESULT)
    else $error("draw did not stop at line end");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (state == S_DECODE && req_stall))
    else $error("accepted word not decoded");

  a_init_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT && stat.clr_last) |=> state == S_IDLE)
    else $error("reset sweep did not finish");

endmodule
`default_nettype wire

// ===== design/line_raster_into_bitmap.sv =====
`default_nettype none
// One-bit raster (192 x 160) with clear, Bresenham line draw and pixel read.
// Request channel: req_valid / req_stall / req; response channel:
// rsp_valid / rsp_stall / rsp. Every request word yields one response word.
// One request is in work at a time; req_stall is high while it runs.
// From acceptance the word is decoded, then (result waits for a free output register):
//   read, rejected draw, unused code: straight to the result state
//   draw: N steps, N = pixels on the line (max(|dx|,|dy|) + 1), one store
//         write per cycle, then the result state
//   clear: all 160 raster rows, one row zeroed per cycle, then the result state
// Next request can be taken in the same cycle that rsp_valid rises, even if rsp is
// still stalled; a finished response then waits in the output register and
// the following one holds in its result state until that word is taken.
// After rst the block sweeps all 160 raster rows white with req_stall
// high, then goes idle.
module line_raster_into_bitmap (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lrb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lrb_pkg::rsp_t rsp
);
  import lrb_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  lrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  lrb_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire
